// File: rtl/dcf_pkg.sv
package dcf_pkg;

  localparam int unsigned RING_DEPTH_DEF = 10;

  localparam int unsigned ADDR_W  = 16;
  localparam int unsigned CHAN_W  = 8;
  localparam int unsigned CMD_W   = 8;
  localparam int unsigned KEY_W   = ADDR_W + CHAN_W + CMD_W;
  localparam int unsigned TIME_W  = 32;
  localparam int unsigned WIN_W   = 16;

  localparam int unsigned PADDR_W = 3;
  localparam int unsigned PDATA_W = 32;

  localparam logic [WIN_W-1:0] WINDOW_RESET = 16'd200;

  // Register index, taken from paddr[2]
  localparam logic REG_WINDOW = 1'b0;

  // One stored command: match key {cmd, channel, address} plus its time stamp
  typedef struct packed {
    logic              valid;
    logic [TIME_W-1:0] stamp;
    logic [KEY_W-1:0]  key;
  } entry_t;

endpackage

// File: rtl/duplicate_command_filter_unit.sv
// Channel | Direction | Handshake          | Payload
// in      | input     | in_valid/in_ready  | in_src_addr, in_channel, in_cmd_code, in_now_ms
// out     | output    | out_valid/out_ready| out_accept
// cfg     | input     | psel/penable/pready| paddr, pwrite, pwdata, prdata (window_ms)
//
// A command is captured into the probe register and judged there, against all
// cells of the history chain at once; one command per cycle is sustained while
// out_ready stays high. An accepted command passes through the probe register,
// then the output register, which holds its result until out_ready takes it.
// rst_n is synchronous: it empties the chain (valid bits only) and resets
// window_ms to 200. A stalled result holds the probe stage; input then waits.
module duplicate_command_filter_unit #(
  parameter int unsigned RING_DEPTH = dcf_pkg::RING_DEPTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,

  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [dcf_pkg::ADDR_W-1:0]    in_src_addr,
  input  logic [dcf_pkg::CHAN_W-1:0]    in_channel,
  input  logic [dcf_pkg::CMD_W-1:0]     in_cmd_code,
  input  logic [dcf_pkg::TIME_W-1:0]    in_now_ms,

  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          out_accept,

  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [dcf_pkg::PADDR_W-1:0]   paddr,
  input  logic [dcf_pkg::PDATA_W-1:0]   pwdata,
  output logic [dcf_pkg::PDATA_W-1:0]   prdata,
  output logic                          pready
);

  // ---------------------------------------------------------------------------
  // Configuration register
  // ---------------------------------------------------------------------------
  logic [dcf_pkg::WIN_W-1:0] window_r;
  logic [dcf_pkg::WIN_W-1:0] window_nxt;
  logic                      cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == dcf_pkg::REG_WINDOW);

  assign window_nxt = cfg_wr ? pwdata[dcf_pkg::WIN_W-1:0] : window_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_r <= dcf_pkg::WINDOW_RESET;
    end else begin
      window_r <= window_nxt;
    end
  end

  // Read back zero-extended; unused addresses read zero
  assign prdata = (paddr[2] == dcf_pkg::REG_WINDOW) ?
                  {{(dcf_pkg::PDATA_W-dcf_pkg::WIN_W){1'b0}}, window_r} :
                  '0;

  // ---------------------------------------------------------------------------
  // Probe register: holds the command being judged
  // ---------------------------------------------------------------------------
  logic                         probe_valid_r;
  logic                         probe_valid_nxt;
  logic [dcf_pkg::KEY_W-1:0]    probe_key_r;
  logic [dcf_pkg::KEY_W-1:0]    probe_key_nxt;
  logic [dcf_pkg::TIME_W-1:0]   probe_now_r;
  logic [dcf_pkg::TIME_W-1:0]   probe_now_nxt;
  logic                         in_fire;
  logic                         judge;
  logic                         is_dup;
  logic                         store;

  // Judge when the output register is free or being drained this cycle
  assign judge    = probe_valid_r && (!out_valid || out_ready);
  assign in_ready = !probe_valid_r || judge;
  assign in_fire  = in_valid && in_ready;

  assign probe_valid_nxt = in_fire ? 1'b1 : (judge ? 1'b0 : probe_valid_r);
  assign probe_key_nxt   = in_fire ? {in_cmd_code, in_channel, in_src_addr} : probe_key_r;
  assign probe_now_nxt   = in_fire ? in_now_ms : probe_now_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      probe_valid_r <= 1'b0;
    end else begin
      probe_valid_r <= probe_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    probe_key_r <= probe_key_nxt;
    probe_now_r <= probe_now_nxt;
  end

  // ---------------------------------------------------------------------------
  // History chain: cell 0 holds the newest accepted command, the last cell the
  // oldest. Storing shifts every entry one cell along and drops the oldest,
  // which matches overwriting the oldest slot of a ring.
  // ---------------------------------------------------------------------------
  dcf_pkg::entry_t        entry_chain [RING_DEPTH+1];
  logic [RING_DEPTH:0]    dup_chain;
  logic [RING_DEPTH-1:0]  valid_vec;

  assign entry_chain[0].valid = 1'b1;
  assign entry_chain[0].stamp = probe_now_r;
  assign entry_chain[0].key   = probe_key_r;
  assign dup_chain[0]         = 1'b0;

  // Store only a command that no live entry duplicates
  assign is_dup = dup_chain[RING_DEPTH];
  assign store  = judge && !is_dup;

  for (genvar g = 0; g < RING_DEPTH; g++) begin : g_cell
    dcf_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .shift_en  (store),
      .entry_i   (entry_chain[g]),
      .entry_o   (entry_chain[g+1]),
      .probe_key (probe_key_r),
      .probe_now (probe_now_r),
      .window    (window_r),
      .dup_i     (dup_chain[g]),
      .dup_o     (dup_chain[g+1])
    );
    assign valid_vec[g] = entry_chain[g+1].valid;
  end

  // ---------------------------------------------------------------------------
  // Output register
  // ---------------------------------------------------------------------------
  logic out_valid_r;
  logic out_valid_nxt;
  logic out_accept_r;
  logic out_accept_nxt;

  assign out_valid_nxt  = judge ? 1'b1 : ((out_valid_r && out_ready) ? 1'b0 : out_valid_r);
  assign out_accept_nxt = judge ? !is_dup : out_accept_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_accept_r <= out_accept_nxt;
  end

  assign out_valid  = out_valid_r;
  assign out_accept = out_accept_r;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------

  // A stored command lands in cell 0 with its key
  a_store_lands: assert property (@(posedge clk) disable iff (!rst_n)
    store |=> valid_vec[0] && (entry_chain[1].key == $past(probe_key_r)))
    else $error("stored command missing from head cell");

  // A dropped duplicate leaves the history untouched
  a_dup_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (judge && is_dup) |=> $stable(valid_vec))
    else $error("history changed on a duplicate");

  // Live entries always fill the chain from the head
  a_valid_packed: assert property (@(posedge clk) disable iff (!rst_n)
    ((({1'b0, valid_vec} + 1'b1) & {1'b0, valid_vec}) == '0))
    else $error("gap in history valid bits");

  // A zero window never reports a duplicate
  a_zero_window: assert property (@(posedge clk) disable iff (!rst_n)
    (judge && (window_r == '0)) |-> !is_dup)
    else $error("duplicate reported with zero window");

  // Each judged command yields a result in the next cycle
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    judge |=> out_valid_r && (out_accept_r == !$past(is_dup)))
    else $error("result not registered after judging");

endmodule

// File: rtl/dcf_cell.sv
module dcf_cell (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             shift_en,
  input  dcf_pkg::entry_t                  entry_i,
  output dcf_pkg::entry_t                  entry_o,
  input  logic [dcf_pkg::KEY_W-1:0]        probe_key,
  input  logic [dcf_pkg::TIME_W-1:0]       probe_now,
  input  logic [dcf_pkg::WIN_W-1:0]        window,
  input  logic                             dup_i,
  output logic                             dup_o
);

  logic                        valid_r;
  logic                        valid_nxt;
  logic [dcf_pkg::TIME_W-1:0]  stamp_r;
  logic [dcf_pkg::TIME_W-1:0]  stamp_nxt;
  logic [dcf_pkg::KEY_W-1:0]   key_r;
  logic [dcf_pkg::KEY_W-1:0]   key_nxt;
  logic [dcf_pkg::TIME_W-1:0]  age;
  logic                        match;

  // Take the neighbour's entry on a shift, else hold
  assign valid_nxt = shift_en ? entry_i.valid : valid_r;
  assign stamp_nxt = shift_en ? entry_i.stamp : stamp_r;
  assign key_nxt   = shift_en ? entry_i.key   : key_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    stamp_r <= stamp_nxt;
    key_r   <= key_nxt;
  end

  // Wrapping age; a stamp ahead of now gives a large age and no match
  assign age   = probe_now - stamp_r;
  assign match = valid_r && (key_r == probe_key) &&
                 (age < {{(dcf_pkg::TIME_W-dcf_pkg::WIN_W){1'b0}}, window});

  assign dup_o = dup_i | match;

  assign entry_o.valid = valid_r;
  assign entry_o.stamp = stamp_r;
  assign entry_o.key   = key_r;

endmodule

// File: sim/dcf_checker.sv
module dcf_checker #(
  parameter int unsigned DEPTH = dcf_pkg::RING_DEPTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,

  input  logic                        in_valid,
  input  logic                        in_ready,
  input  logic [dcf_pkg::ADDR_W-1:0]  in_src_addr,
  input  logic [dcf_pkg::CHAN_W-1:0]  in_channel,
  input  logic [dcf_pkg::CMD_W-1:0]   in_cmd_code,
  input  logic [dcf_pkg::TIME_W-1:0]  in_now_ms,

  input  logic                        out_valid,
  input  logic                        out_ready,
  input  logic                        out_accept,

  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [dcf_pkg::PADDR_W-1:0] paddr,
  input  logic [dcf_pkg::PDATA_W-1:0] pwdata,
  input  logic [dcf_pkg::PDATA_W-1:0] prdata,
  input  logic                        pready,

  output int                          mismatches,
  output int                          pending
);

  // Shadow of the command history and the window register
  logic [dcf_pkg::KEY_W-1:0]  hist_key   [DEPTH];
  logic [dcf_pkg::TIME_W-1:0] hist_stamp [DEPTH];
  logic                       hist_live  [DEPTH];
  int unsigned                next_slot;
  logic [dcf_pkg::WIN_W-1:0]  window_ms;

  // Accept flags still owed by the block, oldest first
  bit                         accept_due [$];

  // Judge one command against the history; store it when it is new
  function automatic bit judge_command(input logic [dcf_pkg::KEY_W-1:0]  key,
                                       input logic [dcf_pkg::TIME_W-1:0] now);
    logic [dcf_pkg::TIME_W-1:0] age;
    logic [dcf_pkg::TIME_W-1:0] limit;
    bit                         dup;
    dup   = 1'b0;
    limit = dcf_pkg::TIME_W'(window_ms);
    for (int i = 0; i < DEPTH; i++) begin
      age = now - hist_stamp[i];
      if (hist_live[i] && hist_key[i] == key && age < limit)
        dup = 1'b1;
    end
    if (dup)
      return 1'b0;
    hist_key[next_slot]   = key;
    hist_stamp[next_slot] = now;
    hist_live[next_slot]  = 1'b1;
    next_slot = (next_slot + 1 == DEPTH) ? 0 : next_slot + 1;
    return 1'b1;
  endfunction

  task automatic note_mismatch(input string what);
    mismatches++;
    if (mismatches <= 10)
      $display("%s", what);
  endtask

  always @(posedge clk) begin : watch
    bit want;
    if (!rst_n) begin
      for (int i = 0; i < DEPTH; i++) begin
        hist_key[i]   = '0;
        hist_stamp[i] = '0;
        hist_live[i]  = 1'b0;
      end
      next_slot = 0;
      window_ms = dcf_pkg::WINDOW_RESET;
      accept_due.delete();
    end else begin
      // Results first: they always belong to older commands
      if (out_valid && out_ready) begin
        if (accept_due.size() == 0) begin
          note_mismatch($sformatf("checker: result accept=%0b with nothing outstanding",
                                  out_accept));
        end else begin
          want = accept_due.pop_front();
          if (out_accept !== want)
            note_mismatch($sformatf("checker: accept expected %0b, got %0b",
                                    want, out_accept));
        end
      end
      if (in_valid && in_ready)
        accept_due.push_back(judge_command({in_cmd_code, in_channel, in_src_addr},
                                           in_now_ms));
      if (psel && penable && pready) begin
        if (pwrite) begin
          if (paddr[dcf_pkg::PADDR_W-1:2] == dcf_pkg::REG_WINDOW)
            window_ms = pwdata[dcf_pkg::WIN_W-1:0];
        end else if (paddr[dcf_pkg::PADDR_W-1:2] == dcf_pkg::REG_WINDOW &&
                     prdata !== dcf_pkg::PDATA_W'(window_ms)) begin
          note_mismatch($sformatf("checker: window read expected %0d, got %0d",
                                  window_ms, prdata));
        end
      end
    end
    pending = accept_due.size();
  end

endmodule

// File: sim/tb.sv
module tb;

  // Register addresses: the window, and an unused slot whose writes must vanish
  localparam logic [dcf_pkg::PADDR_W-1:0] WINDOW_ADDR = {dcf_pkg::REG_WINDOW, 2'b00};
  localparam logic [dcf_pkg::PADDR_W-1:0] SPARE_ADDR  = {~dcf_pkg::REG_WINDOW, 2'b00};

  localparam int unsigned SEG_ITEMS  = 155;
  localparam int unsigned POOL_SIZE  = 6;
  localparam int unsigned LONG_HOLD  = 120;
  localparam logic [dcf_pkg::TIME_W-1:0] FILL_TIME = 32'd1000;

  logic                        clk = 1'b0;
  logic                        rst_n = 1'b0;

  logic                        in_valid = 1'b0;
  logic                        in_ready;
  logic [dcf_pkg::ADDR_W-1:0]  in_src_addr = '0;
  logic [dcf_pkg::CHAN_W-1:0]  in_channel = '0;
  logic [dcf_pkg::CMD_W-1:0]   in_cmd_code = '0;
  logic [dcf_pkg::TIME_W-1:0]  in_now_ms = '0;

  logic                        out_valid;
  logic                        out_ready = 1'b0;
  logic                        out_accept;

  logic                        psel = 1'b0;
  logic                        penable = 1'b0;
  logic                        pwrite = 1'b0;
  logic [dcf_pkg::PADDR_W-1:0] paddr = '0;
  logic [dcf_pkg::PDATA_W-1:0] pwdata = '0;
  logic [dcf_pkg::PDATA_W-1:0] prdata;
  logic                        pready;

  int                          mismatches;
  int                          pending;

  // Idle chances in percent for each side of the block
  int                          send_idle_pct = 0;
  int                          recv_idle_pct = 0;
  // Raised once to make the receiver hold off long enough to back up the input
  bit                          hold_req = 1'b0;

  // Stimulus shaping: current clock, window, and a small pool of hot commands
  logic [dcf_pkg::TIME_W-1:0]  clock_ms;
  logic [dcf_pkg::WIN_W-1:0]   window_now;
  logic [dcf_pkg::KEY_W-1:0]   pool_key  [POOL_SIZE];
  logic [dcf_pkg::TIME_W-1:0]  pool_seen [POOL_SIZE];

  always #5 clk = ~clk;

  duplicate_command_filter_unit dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_src_addr (in_src_addr),
    .in_channel  (in_channel),
    .in_cmd_code (in_cmd_code),
    .in_now_ms   (in_now_ms),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_accept  (out_accept),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  dcf_checker u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_src_addr (in_src_addr),
    .in_channel  (in_channel),
    .in_cmd_code (in_cmd_code),
    .in_now_ms   (in_now_ms),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_accept  (out_accept),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .mismatches  (mismatches),
    .pending     (pending)
  );

  // Offer one command transaction. Enter and leave on a falling edge; valid
  // stays high on return so back-to-back transactions need no extra step.
  task automatic send_cmd(input logic [dcf_pkg::ADDR_W-1:0] addr,
                          input logic [dcf_pkg::CHAN_W-1:0] chan,
                          input logic [dcf_pkg::CMD_W-1:0]  cmd,
                          input logic [dcf_pkg::TIME_W-1:0] now);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid    <= 1'b1;
    in_src_addr <= addr;
    in_channel  <= chan;
    in_cmd_code <= cmd;
    in_now_ms   <= now;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  // One register transaction: setup cycle, then access cycle until pready
  task automatic cfg_access(input bit wr, input logic [dcf_pkg::PADDR_W-1:0] addr,
                            input logic [dcf_pkg::PDATA_W-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= addr;
    pwdata  <= data;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
  endtask

  // Drop valid and wait until every result is home, plus the pipeline depth
  task automatic settle();
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // Mostly hot commands, re-sent inside, around or past the window; the rest near
  // misses and fresh commands. The clock may also step backwards or jump anywhere.
  task automatic send_random();
    int unsigned                 k;
    int unsigned                 pick;
    logic [dcf_pkg::KEY_W-1:0]   key;
    logic [dcf_pkg::TIME_W-1:0]  t;
    k    = $urandom_range(0, POOL_SIZE - 1);
    pick = $urandom_range(0, 99);
    key  = pool_key[k];
    if (pick < 15)
      key = $urandom;
    else if (pick < 25)
      key = key ^ (32'(1) << $urandom_range(0, dcf_pkg::KEY_W - 1));
    pick = $urandom_range(0, 99);
    if (pick < 40)
      t = clock_ms + $urandom_range(0, window_now / 4 + 3);
    else if (pick < 65)
      t = pool_seen[k] + window_now - 1 + $urandom_range(0, 2);
    else if (pick < 80)
      t = pool_seen[k] + $urandom_range(0, window_now);
    else if (pick < 90)
      t = clock_ms - $urandom_range(1, 1000);
    else
      t = $urandom;
    pool_seen[k] = t;
    clock_ms     = t;
    send_cmd(key[15:0], key[23:16], key[31:24], t);
  endtask

  // Set a new window once the block is idle, refresh the pool and run a batch
  task automatic run_segment(input int unsigned n, input logic [dcf_pkg::PDATA_W-1:0] wdata,
                             input bit press);
    settle();
    cfg_access(1'b1, WINDOW_ADDR, wdata);
    cfg_access(1'b0, WINDOW_ADDR, '0);
    window_now = wdata[dcf_pkg::WIN_W-1:0];
    for (int i = 0; i < POOL_SIZE; i++) begin
      pool_key[i]  = $urandom;
      pool_seen[i] = clock_ms;
    end
    for (int i = 0; i < n; i++) begin
      if (press && i == n / 3)
        hold_req = 1'b1;
      send_random();
    end
  endtask

  // Receiver: random back-pressure, plus one long hold counted here
  initial begin : receiver
    int unsigned hold_left;
    bit          hold_done;
    hold_left = 0;
    hold_done = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req && !hold_done) begin
        hold_left = LONG_HOLD;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        out_ready <= 1'b0;
        hold_left--;
      end else begin
        out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
    end
  end

  // Hard stop in case the block hangs
  initial begin : watchdog
    #5_000_000;
    $display("tb: failure");
    $finish;
  end

  initial begin : stimulus
    clock_ms   = '0;
    window_now = dcf_pkg::WINDOW_RESET;
    send_idle_pct = 17;
    recv_idle_pct = 51;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Window must read back its reset value
    cfg_access(1'b0, WINDOW_ADDR, '0);

    // Empty history: an all-zero command at time zero must not hit a blank entry
    send_cmd('0, '0, '0, 32'd0);
    send_cmd('0, '0, '0, 32'd0);
    // Window edge: one short of the window is a repeat, the window itself is not
    send_cmd('0, '0, '0, 32'd199);
    send_cmd('0, '0, '0, 32'd200);
    send_cmd('0, '0, '0, 32'd399);
    // All-ones fields, then a repeat just after the clock wraps
    send_cmd('1, '1, '1, 32'hFFFF_FFFF);
    send_cmd('1, '1, '1, 32'd0);
    // Stamp in the future looks very old, so it passes
    send_cmd('1, '1, '1, 32'hFFFF_FF00);
    // Fill the ring past its depth; the first of these gets overwritten
    for (int i = 0; i <= dcf_pkg::RING_DEPTH_DEF; i++)
      send_cmd(dcf_pkg::ADDR_W'(16'h0100 + i), 8'h01, 8'h01, FILL_TIME);
    send_cmd(16'h0100, 8'h01, 8'h01, FILL_TIME);
    send_cmd(16'h0102, 8'h01, 8'h01, FILL_TIME);

    // Zero window: nothing is ever young enough to be a repeat
    settle();
    cfg_access(1'b1, WINDOW_ADDR, 32'h5A5A_0000);
    send_cmd(16'h1234, 8'h56, 8'h78, 32'd50);
    send_cmd(16'h1234, 8'h56, 8'h78, 32'd50);

    // Write to the unused slot must leave the window alone
    settle();
    cfg_access(1'b1, SPARE_ADDR, 32'h0000_1234);
    cfg_access(1'b0, WINDOW_ADDR, '0);
    send_cmd(16'h1234, 8'h56, 8'h78, 32'd50);

    // Random part: sender lightly idle, receiver often stalled
    clock_ms = $urandom;
    run_segment(SEG_ITEMS, 32'hFFFF_FFFF, 1'b0);
    run_segment(SEG_ITEMS, {16'($urandom), 16'd1}, 1'b0);

    // Swap the idle rates
    send_idle_pct = 51;
    recv_idle_pct = 17;
    run_segment(SEG_ITEMS, 32'd300, 1'b0);
    run_segment(SEG_ITEMS, $urandom, 1'b0);

    // Full rate, with one long receiver hold to back the pipeline up
    send_idle_pct = 0;
    recv_idle_pct = 0;
    run_segment(SEG_ITEMS, 32'd200, 1'b1);
    run_segment(SEG_ITEMS, 32'd1000, 1'b0);

    // Drain and give the verdict
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (8) @(negedge clk);
    if (mismatches == 0 && pending == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule
